FILE: design/rgb2hsv_pkg.sv
// ============================================================================
// rgb2hsv_pkg
// Shared constants and types for the RGB to HSV converter.
// ============================================================================
`default_nettype none

package rgb2hsv_pkg;

    // Default configuration of the converter.
    localparam int DEF_COMPONENT_BITS    = 8;
    localparam int DEF_HUE_FRACTION_BITS = 6;

    // Angles in whole degrees and sector offsets in units of 60 degrees.
    localparam int SECTOR_DEG   = 60;
    localparam int FULL_DEG     = 360;
    localparam int GREEN_SECTOR = 2;
    localparam int BLUE_SECTOR  = 4;

    // Which component is the largest, with ties resolved red, green, blue.
    typedef enum logic [1:0] {
        SECTOR_RED   = 2'd0,
        SECTOR_GREEN = 2'd1,
        SECTOR_BLUE  = 2'd2
    } t_sector;

endpackage

`default_nettype wire

FILE: design/rgb2hsv_divider.sv
// ============================================================================
// rgb2hsv_divider
// Pipelined restoring divider, one quotient bit per step stage, padded with pass stages.
// ============================================================================
`default_nettype none

module rgb2hsv_divider #(
    parameter int DEN_W = 8,   // divisor width
    parameter int Q_W   = 8,   // quotient width, at least 2
    parameter int LAT   = 8    // number of register stages, at least Q_W
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [DEN_W+Q_W-1:0]   i_num,
    input  wire logic [DEN_W-1:0]       i_den,
    output logic      [Q_W-1:0]         o_quo,
    output logic      [DEN_W-1:0]       o_rem
);

    // The caller guarantees num >> Q_W < den, so the quotient fits in Q_W bits
    // and the upper numerator bits form the starting partial remainder.
    logic [DEN_W-1:0] s_rem [0:LAT];
    logic [Q_W-1:0]   s_w   [0:LAT];
    logic [DEN_W-1:0] s_den [0:LAT];

    assign s_rem[0] = i_num[DEN_W+Q_W-1:Q_W];
    assign s_w[0]   = i_num[Q_W-1:0];
    assign s_den[0] = i_den;

    for (genvar k = 1; k <= LAT; k++) begin : g_stage
        logic [DEN_W-1:0] r_rem;
        logic [Q_W-1:0]   r_w;
        logic [DEN_W-1:0] r_den;
        logic [DEN_W-1:0] n_rem;
        logic [Q_W-1:0]   n_w;

        if (k <= Q_W) begin : g_step
            logic [DEN_W:0] trial;
            logic           fits;

            // Bring down the next numerator bit and try to subtract.
            always_comb begin
                trial = {s_rem[k-1], s_w[k-1][Q_W-1]};
                fits  = (trial >= {1'b0, s_den[k-1]});
                n_rem = fits ? DEN_W'(trial - {1'b0, s_den[k-1]}) : trial[DEN_W-1:0];
                n_w   = {s_w[k-1][Q_W-2:0], fits};
            end
        end else begin : g_pass
            // Padding stages keep this divider aligned with a longer one.
            always_comb begin
                n_rem = s_rem[k-1];
                n_w   = s_w[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_w   <= n_w;
                r_den <= s_den[k-1];
            end
        end

        assign s_rem[k] = r_rem;
        assign s_w[k]   = r_w;
        assign s_den[k] = r_den;
    end

    assign o_quo = s_w[LAT];
    assign o_rem = s_rem[LAT];

endmodule

`default_nettype wire

FILE: design/rgb_to_hsv_converter.sv
// ============================================================================
// rgb_to_hsv_converter
// Streaming RGB to HSV conversion in fixed point, one pixel per clock while the output is not held.
// ============================================================================
// The converter takes one RGB pixel per clock while not stalled and returns value (the largest
// component), saturation as floor(FULL * (max - min) / max) with FULL the
// largest component code, and hue in units of 1/2^HUE_FRACTION_BITS degree,
// floored, in the range 0 to just below 360 degrees. Gray and black pixels
// report hue_defined low with hue and saturation both zero. The datapath is a
// fixed pipeline: one stage finds max, min and the hue sector, one stage forms
// the two dividends, then two restoring dividers run side by side with one
// quotient bit per stage, and a final stage applies the sector offset and the
// wrap of negative hues. The dividers set the depth of the pipeline, and the
// sustained rate is one pixel per clock while the output is not held. When the
// output is held, one more request is taken into a skid register before
// o_stall rises, and that request waits there until the output moves again.
// o_stall stays high through the first cycle in which the pipeline moves, so
// each hold costs one input slot. The converter keeps nothing between pixels.
// ============================================================================
`default_nettype none

module rgb_to_hsv_converter #(
    parameter int COMPONENT_BITS    = rgb2hsv_pkg::DEF_COMPONENT_BITS,
    parameter int HUE_FRACTION_BITS = rgb2hsv_pkg::DEF_HUE_FRACTION_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Pixel requests.
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [COMPONENT_BITS-1:0]   i_red_in,
    input  wire logic [COMPONENT_BITS-1:0]   i_green_in,
    input  wire logic [COMPONENT_BITS-1:0]   i_blue_in,
    // Converted pixels.
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [$clog2(rgb2hsv_pkg::FULL_DEG << HUE_FRACTION_BITS)-1:0] o_hue_out,
    output logic                             o_hue_defined,
    output logic [COMPONENT_BITS-1:0]        o_saturation_out,
    output logic [COMPONENT_BITS-1:0]        o_value_out
);

    import rgb2hsv_pkg::*;

    localparam int C      = COMPONENT_BITS;
    localparam int UNIT   = SECTOR_DEG << HUE_FRACTION_BITS;   // 60 degrees
    localparam int FULL   = FULL_DEG << HUE_FRACTION_BITS;     // 360 degrees
    localparam int HUE_W  = $clog2(FULL);
    localparam int Q_H    = $clog2(UNIT + 1);                  // hue quotient bits
    localparam int HNUM_W = C + Q_H;
    localparam int LAT    = (C > Q_H) ? C : Q_H;

    localparam logic [Q_H-1:0]   UNIT_K  = Q_H'(UNIT);
    localparam logic [HUE_W-1:0] FULL_K  = HUE_W'(FULL);
    localparam logic [HUE_W-1:0] GREEN_K = HUE_W'(GREEN_SECTOR * UNIT);
    localparam logic [HUE_W-1:0] BLUE_K  = HUE_W'(BLUE_SECTOR * UNIT);

    // ------------------------------------------------------------------------
    // Flow control. The whole pipeline moves together unless a finished
    // result is waiting at the output. A request that arrives while the
    // pipeline is held lands in the skid register, which then raises o_stall.
    // ------------------------------------------------------------------------
    logic         adv;
    logic         in_take;
    logic         r_skid_valid;
    logic [C-1:0] r_skid_r, r_skid_g, r_skid_b;

    assign adv     = !(o_valid && i_stall);
    assign o_stall = r_skid_valid;
    assign in_take = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (adv) begin
            r_skid_valid <= 1'b0;
        end else if (in_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!adv && in_take) begin
            r_skid_r <= i_red_in;
            r_skid_g <= i_green_in;
            r_skid_b <= i_blue_in;
        end
    end

    // The pixel that enters the first stage when the pipeline moves.
    logic         src_valid;
    logic [C-1:0] src_r, src_g, src_b;

    always_comb begin
        if (r_skid_valid) begin
            src_valid = 1'b1;
            src_r     = r_skid_r;
            src_g     = r_skid_g;
            src_b     = r_skid_b;
        end else begin
            src_valid = in_take;
            src_r     = i_red_in;
            src_g     = i_green_in;
            src_b     = i_blue_in;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: largest and smallest component, sector and hue difference.
    // ------------------------------------------------------------------------
    logic [C-1:0] s1_mx, s1_mn, s1_plus, s1_minus, s1_diff;
    t_sector      s1_sector;
    logic         s1_neg;

    always_comb begin
        s1_mx = src_r;
        if (src_g > s1_mx) s1_mx = src_g;
        if (src_b > s1_mx) s1_mx = src_b;
        s1_mn = src_r;
        if (src_g < s1_mn) s1_mn = src_g;
        if (src_b < s1_mn) s1_mn = src_b;

        if (src_r == s1_mx) begin
            s1_sector = SECTOR_RED;
            s1_plus   = src_g;
            s1_minus  = src_b;
        end else if (src_g == s1_mx) begin
            s1_sector = SECTOR_GREEN;
            s1_plus   = src_b;
            s1_minus  = src_r;
        end else begin
            s1_sector = SECTOR_BLUE;
            s1_plus   = src_r;
            s1_minus  = src_g;
        end

        s1_neg  = (s1_plus < s1_minus);
        s1_diff = s1_neg ? (s1_minus - s1_plus) : (s1_plus - s1_minus);
    end

    logic         r_s1_valid;
    logic [C-1:0] r_s1_mx, r_s1_d, r_s1_diff;
    t_sector      r_s1_sector;
    logic         r_s1_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= src_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_mx     <= s1_mx;
            r_s1_d      <= s1_mx - s1_mn;
            r_s1_diff   <= s1_diff;
            r_s1_sector <= s1_sector;
            r_s1_neg    <= s1_neg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: dividends. Saturation divides FULL * d by max, hue divides
    // 60 degrees times the difference by d.
    // ------------------------------------------------------------------------
    logic              r_s2_valid;
    logic [2*C-1:0]    r_s2_sat_num;
    logic [HNUM_W-1:0] r_s2_hue_num;
    logic [C-1:0]      r_s2_mx, r_s2_d;
    t_sector           r_s2_sector;
    logic              r_s2_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_sat_num <= {r_s1_d, {C{1'b0}}} - {{C{1'b0}}, r_s1_d};
            r_s2_hue_num <= HNUM_W'(r_s1_diff) * HNUM_W'(UNIT_K);
            r_s2_mx      <= r_s1_mx;
            r_s2_d       <= r_s1_d;
            r_s2_sector  <= r_s1_sector;
            r_s2_neg     <= r_s1_neg;
        end
    end

    // ------------------------------------------------------------------------
    // Dividers, both LAT stages deep. For gray pixels the divisor may be zero;
    // those quotients are discarded at the output.
    // ------------------------------------------------------------------------
    logic [C-1:0]   sat_quo;
    logic [C-1:0]   sat_rem;
    logic [Q_H-1:0] hue_quo;
    logic [C-1:0]   hue_rem;

    rgb2hsv_divider #(
        .DEN_W (C),
        .Q_W   (C),
        .LAT   (LAT)
    ) u_sat_div (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_s2_sat_num),
        .i_den (r_s2_mx),
        .o_quo (sat_quo),
        .o_rem (sat_rem)
    );

    rgb2hsv_divider #(
        .DEN_W (C),
        .Q_W   (Q_H),
        .LAT   (LAT)
    ) u_hue_div (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_s2_hue_num),
        .i_den (r_s2_d),
        .o_quo (hue_quo),
        .o_rem (hue_rem)
    );

    // Side information travels next to the dividers.
    logic         r_dl_valid   [1:LAT];
    logic [C-1:0] r_dl_mx      [1:LAT];
    t_sector      r_dl_sector  [1:LAT];
    logic         r_dl_neg     [1:LAT];
    logic         r_dl_defined [1:LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LAT; k++) begin
                r_dl_valid[k] <= 1'b0;
            end
        end else if (adv) begin
            r_dl_valid[1] <= r_s2_valid;
            for (int k = 2; k <= LAT; k++) begin
                r_dl_valid[k] <= r_dl_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dl_mx[1]      <= r_s2_mx;
            r_dl_sector[1]  <= r_s2_sector;
            r_dl_neg[1]     <= r_s2_neg;
            r_dl_defined[1] <= (r_s2_d != '0);
            for (int k = 2; k <= LAT; k++) begin
                r_dl_mx[k]      <= r_dl_mx[k-1];
                r_dl_sector[k]  <= r_dl_sector[k-1];
                r_dl_neg[k]     <= r_dl_neg[k-1];
                r_dl_defined[k] <= r_dl_defined[k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Final stage: a negative hue term is floored by rounding its magnitude
    // up, then the sector offset is applied. In the red sector a negative
    // term wraps around through 360 degrees.
    // ------------------------------------------------------------------------
    logic [HUE_W-1:0] q_floor, q_ceil, hue_calc;

    always_comb begin
        q_floor = HUE_W'(hue_quo);
        q_ceil  = q_floor + HUE_W'(hue_rem != '0);
        case (r_dl_sector[LAT])
            SECTOR_RED:   hue_calc = r_dl_neg[LAT] ? (FULL_K - q_ceil) : q_floor;
            SECTOR_GREEN: hue_calc = r_dl_neg[LAT] ? (GREEN_K - q_ceil) : (GREEN_K + q_floor);
            SECTOR_BLUE:  hue_calc = r_dl_neg[LAT] ? (BLUE_K - q_ceil) : (BLUE_K + q_floor);
            default:      hue_calc = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= r_dl_valid[LAT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_value_out   <= r_dl_mx[LAT];
            o_hue_defined <= r_dl_defined[LAT];
            if (r_dl_defined[LAT]) begin
                o_hue_out        <= hue_calc;
                o_saturation_out <= sat_quo;
            end else begin
                o_hue_out        <= '0;
                o_saturation_out <= '0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    a_skid_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(o_valid && i_stall))
        else $error("skid register filled while the pipeline was moving");

    a_hue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue_out < FULL_K))
        else $error("hue at or beyond 360 degrees");

    a_gray_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hue_defined) |-> (o_hue_out == '0 && o_saturation_out == '0))
        else $error("gray pixel with nonzero hue or saturation");

    a_colored_has_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hue_defined) |-> (o_saturation_out != '0 && o_value_out != '0))
        else $error("colored pixel with zero saturation or value");

    a_sat_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dl_valid[LAT] && r_dl_defined[LAT]) |-> (sat_rem < r_dl_mx[LAT]))
        else $error("saturation divider remainder not below its divisor");

endmodule

`default_nettype wire
